// ===== rtl/crlfsl_pkg.sv =====
// shared types, codes and status word tables for the crlf status line deframer
`default_nettype none

package crlfsl_pkg;

  localparam int LINE_LIMIT_DEF = 1024;
  localparam int WORD_LIMIT_DEF = 16;

  localparam int NUM_STAT = 9;
  localparam int LEN_W = 34;

  localparam logic [LEN_W-1:0] BODY_CAP_RST = 34'd67108864;

  // status codes
  localparam logic [3:0] ST_UNKNOWN = 4'd9;
  localparam logic [3:0] ST_FRAMING = 4'd10;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_BODY = 1'b1;

  // register index, taken from paddr[3]
  localparam logic REG_BODY_CAP = 1'b0;

  // special bytes
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  localparam logic [3:0] DIGITS_POISON = 4'd15;
  localparam logic [3:0] DIGITS_MAX = 4'd10;
  localparam logic [3:0] FWL_MAX = 4'd15;

  typedef enum logic [1:0] {
    BM_LINE,
    BM_PASS,
    BM_DROP
  } body_mode_t;

  // line report from the parser at the lf
  typedef struct packed {
    logic [3:0]       status;
    logic [4:0]       word_count;
    logic             has_body;
    logic [LEN_W-1:0] body_length;
  } line_rpt_t;

  // one result transaction
  typedef struct packed {
    logic             kind;
    logic [3:0]       status;
    logic [4:0]       word_count;
    logic             has_body;
    logic [LEN_W-1:0] body_length;
    logic             body_too_large;
    logic [7:0]       body_byte;
    logic             last;
  } result_t;

  // status word text, right aligned
  function automatic logic [71:0] stat_name(input logic [3:0] i);
    logic [71:0] s;
    case (i)
      4'd0:    s = 72'("si");
      4'd1:    s = 72'("keresebyr");
      4'd2:    s = 72'("sentyre");
      4'd3:    s = 72'("ezhazebyr");
      4'd4:    s = 72'("vazoj");
      4'd5:    s = 72'("ramuzhu");
      4'd6:    s = 72'("wuwoji");
      4'd7:    s = 72'("byr");
      4'd8:    s = 72'("koja");
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] stat_len(input logic [3:0] i);
    logic [3:0] n;
    case (i)
      4'd0:    n = 4'd2;
      4'd1:    n = 4'd9;
      4'd2:    n = 4'd7;
      4'd3:    n = 4'd9;
      4'd4:    n = 4'd5;
      4'd5:    n = 4'd7;
      4'd6:    n = 4'd6;
      4'd7:    n = 4'd3;
      4'd8:    n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // candidates whose length equals the first word length
  function automatic logic [NUM_STAT-1:0] stat_len_mask(input logic [3:0] fwl);
    logic [NUM_STAT-1:0] m;
    for (int i = 0; i < NUM_STAT; i++) begin
      m[i] = stat_len(4'(i)) == fwl;
    end
    return m;
  endfunction

  // candidates whose character at position fwl equals b
  function automatic logic [NUM_STAT-1:0] stat_char_mask(input logic [3:0] fwl,
                                                         input logic [7:0] b);
    logic [NUM_STAT-1:0] m;
    logic [71:0]         nm;
    logic [3:0]          len;
    logic [3:0]          idx;
    for (int i = 0; i < NUM_STAT; i++) begin
      nm = stat_name(4'(i));
      len = stat_len(4'(i));
      idx = len - fwl - 4'd1;
      m[i] = (fwl < len) && (nm[{idx, 3'b000} +: 8] == b);
    end
    return m;
  endfunction

  function automatic logic [7:0] kyx_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = "k";
      2'd1:    c = "y";
      2'd2:    c = "x";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crlfsl_line.sv =====
// status line parser: per byte word, status and count tracking, report at the lf
`default_nettype none

module crlfsl_line #(
  parameter int LINE_LIMIT = crlfsl_pkg::LINE_LIMIT_DEF,
  parameter int WORD_LIMIT = crlfsl_pkg::WORD_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic [7:0]            rx_byte,
  output logic                       eol,
  output crlfsl_pkg::line_rpt_t      rpt
);

  localparam int LL_W = $clog2(LINE_LIMIT + 2);
  localparam int WS_W = $clog2(WORD_LIMIT + 1);

  typedef struct packed {
    logic [LL_W-1:0]                     len;
    logic                                cr;
    logic [WS_W-1:0]                     words;
    logic                                after_space;
    logic                                bad;
    logic [crlfsl_pkg::NUM_STAT-1:0]     cands;
    logic [3:0]                          fwl;
    logic [1:0]                          kyx_prog;
    logic                                kyx_dead;
    logic                                prior_kyx;
    logic [crlfsl_pkg::LEN_W-1:0]        cnt_val;
    logic [3:0]                          cnt_dig;
    logic                                cnt_ok;
    logic                                text_done;
  } line_t;

  localparam line_t LINE_CLR = '{
    len: '0, cr: 1'b0, words: '0, after_space: 1'b0, bad: 1'b0,
    cands: '1, fwl: '0, kyx_prog: '0, kyx_dead: 1'b0, prior_kyx: 1'b0,
    cnt_val: '0, cnt_dig: '0, cnt_ok: 1'b0, text_done: 1'b0
  };

  // one text byte into the word state
  function automatic line_t text_step(input line_t s, input logic [7:0] b);
    line_t           n;
    logic [WS_W-1:0] ws1;
    n = s;
    ws1 = (s.words == '0) ? WS_W'(1) : s.words;
    if (!(s.text_done || s.bad)) begin
      if (b == crlfsl_pkg::CH_NUL) begin
        n.text_done = 1'b1;
      end else begin
        n.words = ws1;
        if (b == crlfsl_pkg::CH_SP) begin
          if (s.after_space) begin
            n.bad = 1'b1;
          end else begin
            if (ws1 == WS_W'(1)) begin
              n.cands = s.cands & crlfsl_pkg::stat_len_mask(s.fwl);
            end
            n.prior_kyx = !s.kyx_dead && (s.kyx_prog == 2'd3);
            n.kyx_prog = '0;
            n.kyx_dead = 1'b0;
            n.cnt_val = '0;
            n.cnt_dig = '0;
            n.cnt_ok = 1'b0;
            if (ws1 >= WS_W'(WORD_LIMIT)) begin
              n.bad = 1'b1;
            end else begin
              n.words = ws1 + WS_W'(1);
            end
            n.after_space = 1'b1;
          end
        end else begin
          n.after_space = 1'b0;
          if (ws1 == WS_W'(1)) begin
            n.cands = s.cands & crlfsl_pkg::stat_char_mask(s.fwl, b);
            if (s.fwl < crlfsl_pkg::FWL_MAX) begin
              n.fwl = s.fwl + 4'd1;
            end
          end
          if (!s.kyx_dead) begin
            if (s.kyx_prog != 2'd3 && crlfsl_pkg::kyx_char(s.kyx_prog) == b) begin
              n.kyx_prog = s.kyx_prog + 2'd1;
            end else begin
              n.kyx_dead = 1'b1;
            end
          end
          if (s.cnt_dig != crlfsl_pkg::DIGITS_POISON) begin
            if (b < crlfsl_pkg::CH_0 || b > crlfsl_pkg::CH_9 ||
                (s.cnt_dig == 4'd1 && s.cnt_val == '0) ||
                s.cnt_dig >= crlfsl_pkg::DIGITS_MAX) begin
              n.cnt_dig = crlfsl_pkg::DIGITS_POISON;
              n.cnt_ok = 1'b0;
            end else begin
              // times ten by shift and add, wraps at 34 bits
              n.cnt_val = (s.cnt_val << 3) + (s.cnt_val << 1) +
                          crlfsl_pkg::LEN_W'(b - crlfsl_pkg::CH_0);
              n.cnt_dig = s.cnt_dig + 4'd1;
              n.cnt_ok = 1'b1;
            end
          end
        end
      end
    end
    return n;
  endfunction

  line_t s_r;
  line_t s_nxt;
  line_t s_cr;

  assign eol = step_en && (rx_byte == crlfsl_pkg::CH_LF);

  always_comb begin
    s_cr = s_r.cr ? text_step(s_r, crlfsl_pkg::CH_CR) : s_r;
    s_nxt = s_r;
    if (step_en) begin
      if (rx_byte == crlfsl_pkg::CH_LF) begin
        s_nxt = LINE_CLR;
      end else begin
        s_nxt = s_cr;
        if (s_r.len <= LL_W'(LINE_LIMIT)) begin
          s_nxt.len = s_r.len + LL_W'(1);
        end
        if (rx_byte == crlfsl_pkg::CH_CR) begin
          s_nxt.cr = 1'b1;
        end else begin
          s_nxt = text_step(s_nxt, rx_byte);
          s_nxt.cr = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= LINE_CLR;
    end else begin
      s_r <= s_nxt;
    end
  end

  // report from the state held before the lf
  logic [LL_W-1:0]                 content;
  logic                            err;
  logic                            cnt_err;
  logic [crlfsl_pkg::NUM_STAT-1:0] cands_fin;
  logic [3:0]                      st;
  logic                            hb;

  always_comb begin
    content = s_r.cr ? (s_r.len - LL_W'(1)) : s_r.len;
    err = !s_r.cr || s_r.bad || (content > LL_W'(LINE_LIMIT - 1)) ||
          (s_r.words == '0) || s_r.after_space;
    cands_fin = (s_r.words == WS_W'(1)) ?
                (s_r.cands & crlfsl_pkg::stat_len_mask(s_r.fwl)) : s_r.cands;
    st = crlfsl_pkg::ST_UNKNOWN;
    for (int i = crlfsl_pkg::NUM_STAT - 1; i >= 0; i--) begin
      if (cands_fin[i]) begin
        st = 4'(i);
      end
    end
    hb = (s_r.words >= WS_W'(2)) && s_r.prior_kyx;
    cnt_err = hb && !s_r.cnt_ok;
    if (err || cnt_err) begin
      rpt = '0;
      rpt.status = crlfsl_pkg::ST_FRAMING;
    end else begin
      rpt.status = st;
      rpt.word_count = 5'(s_r.words);
      rpt.has_body = hb;
      rpt.body_length = hb ? s_r.cnt_val : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crlfsl_outq.sv =====
// two entry result queue that decouples the parser from the output stall
`default_nettype none

module crlfsl_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire crlfsl_pkg::result_t push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output crlfsl_pkg::result_t      out_data
);

  crlfsl_pkg::result_t q0_r;
  crlfsl_pkg::result_t q1_r;
  logic [1:0]          cnt_r;
  logic [1:0]          cnt_nxt;
  logic                pop;

  assign out_valid = cnt_r != 2'd0;
  assign full = cnt_r == 2'd2;
  assign out_data = q0_r;
  assign pop = out_valid && !out_stall;

  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0_r <= (cnt_r == 2'd2) ? q1_r : push_data;
      if (cnt_r == 2'd2 && push) begin
        q1_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        q0_r <= push_data;
      end else begin
        q1_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crlf_status_line_body_deframer_unit.sv =====
// top level: crlf status line parser, body pass-through and body cap register
//
//   channel | ports                          | carries
//   --------+--------------------------------+------------------------------------
//   in      | in_valid / in_stall            | one received byte per transaction
//   out     | out_valid / out_stall          | line report at lf, or one body byte
//   cfg     | cfg_psel ... cfg_pready (apb)  | body_cap at byte address 0, 64 bit
//
// one byte is taken per cycle while in_stall is low; the parser state and the body counter settle
// in the cycle of acceptance and the result lands in a two entry output queue
// each result is registered in the output queue and is driven to the output from its head entry
// in_stall rises only when both queue entries hold results, so bytes that give
// no result and one waiting result never hold up the input
// rst_n is synchronous: line state cleared, line mode, body_cap 67108864
`default_nettype none

module crlf_status_line_body_deframer_unit #(
  parameter int LINE_LIMIT = crlfsl_pkg::LINE_LIMIT_DEF,
  parameter int WORD_LIMIT = crlfsl_pkg::WORD_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [3:0]       out_status,
  output logic [4:0]       out_word_count,
  output logic             out_has_body,
  output logic [33:0]      out_body_length,
  output logic             out_body_too_large,
  output logic [7:0]       out_body_byte,
  output logic             out_last,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int LEN_W = crlfsl_pkg::LEN_W;

  // configuration register
  logic [LEN_W-1:0] cap_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[3] == crlfsl_pkg::REG_BODY_CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= crlfsl_pkg::BODY_CAP_RST;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    case (cfg_paddr[3])
      crlfsl_pkg::REG_BODY_CAP: cfg_prdata = 64'(cap_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // input transaction and body mode
  logic                   acc;
  logic                   full;
  crlfsl_pkg::body_mode_t mode_r;
  crlfsl_pkg::body_mode_t mode_nxt;
  logic [LEN_W-1:0]       rem_r;
  logic [LEN_W-1:0]       rem_nxt;
  logic [LEN_W-1:0]       rem_dec;
  logic                   body_active;
  logic                   line_step;

  assign in_stall = full;
  assign acc = in_valid && !in_stall;

  // a body with nothing left counts as line mode
  assign body_active = (mode_r != crlfsl_pkg::BM_LINE) && (rem_r != '0);
  assign line_step = acc && !body_active;
  assign rem_dec = rem_r - LEN_W'(1);

  // line parser
  logic                  eol;
  crlfsl_pkg::line_rpt_t rpt;
  logic                  rpt_ok;
  logic                  too_large;

  crlfsl_line #(
    .LINE_LIMIT(LINE_LIMIT),
    .WORD_LIMIT(WORD_LIMIT)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (line_step),
    .rx_byte (in_rx_byte),
    .eol     (eol),
    .rpt     (rpt)
  );

  assign rpt_ok = rpt.status != crlfsl_pkg::ST_FRAMING;
  assign too_large = rpt.has_body && (rpt.body_length > cap_r);

  // body mode next state
  always_comb begin
    mode_nxt = mode_r;
    rem_nxt = rem_r;
    if (acc) begin
      if (body_active) begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          mode_nxt = crlfsl_pkg::BM_LINE;
        end
      end else begin
        mode_nxt = crlfsl_pkg::BM_LINE;
        // a good report with a nonzero body switches to body mode
        if (eol && rpt_ok && rpt.has_body && rpt.body_length != '0) begin
          mode_nxt = too_large ? crlfsl_pkg::BM_DROP : crlfsl_pkg::BM_PASS;
          rem_nxt = rpt.body_length;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= crlfsl_pkg::BM_LINE;
      rem_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      rem_r <= rem_nxt;
    end
  end

  // result transaction: body byte in pass mode, report at the lf
  logic                push;
  crlfsl_pkg::result_t push_data;

  always_comb begin
    push = 1'b0;
    push_data = '0;
    if (body_active) begin
      push = acc && (mode_r == crlfsl_pkg::BM_PASS);
      push_data.kind = crlfsl_pkg::KIND_BODY;
      push_data.body_byte = in_rx_byte;
      push_data.last = rem_dec == '0;
    end else begin
      push = acc && eol;
      push_data.kind = crlfsl_pkg::KIND_REPORT;
      push_data.status = rpt.status;
      push_data.word_count = rpt.word_count;
      push_data.has_body = rpt.has_body;
      push_data.body_length = rpt.body_length;
      push_data.body_too_large = rpt_ok && too_large;
    end
  end

  crlfsl_pkg::result_t out_data;

  crlfsl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_kind = out_data.kind;
  assign out_status = out_data.status;
  assign out_word_count = out_data.word_count;
  assign out_has_body = out_data.has_body;
  assign out_body_length = out_data.body_length;
  assign out_body_too_large = out_data.body_too_large;
  assign out_body_byte = out_data.body_byte;
  assign out_last = out_data.last;

endmodule

`default_nettype wire
